@@ sv/fsel_pkg.sv @@
// Shared constants, types and tables of the fuzzy speed selector.
`default_nettype none

package fsel_pkg;

	localparam int DEV_W    = 16;
	localparam int CTR_W    = 15;
	localparam int NUM_CTR  = 7;
	localparam int IDX_W    = 3;
	localparam int LVL_W    = 3;
	localparam int SEG_W    = 3;

	localparam int DEV_MAX  = 130;
	localparam int RATE_MAX = 65;
	localparam int SCL_MAX  = 100;
	localparam int SEG_NUM  = 6;
	localparam int SEG_STEP = 16;

	localparam int DCL_W    = 8;
	localparam int RCL_W    = 7;
	localparam int SCL_W    = 7;

	// Scaling by 100/130 and 100/65 is done as a multiply by a rounded-up
	// reciprocal of 13 and a right shift, exact over the clamped range.
	localparam int RECIP_SH = 16;
	localparam int RECIP13  = (2 ** RECIP_SH + 12) / 13;
	localparam int DEV_MUL  = 10 * RECIP13;
	localparam int RATE_MUL = 20 * RECIP13;
	localparam int SPROD_W  = 23;

	localparam int WGT_W    = 7;
	localparam int PROD_W   = WGT_W + CTR_W;
	localparam int NUM_W    = PROD_W + 2;
	localparam int DEN_W    = 9;
	localparam int QUO_W    = CTR_W;

	typedef logic [CTR_W-1:0] center_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	localparam center_t CENTER_RESET [NUM_CTR] = '{
		15'd68, 15'd70, 15'd73, 15'd76, 15'd79, 15'd82, 15'd100
	};

	localparam logic [LVL_W-1:0] RULE_TBL [NUM_CTR][NUM_CTR] = '{
		'{3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1},
		'{3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1},
		'{3'd4, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd0},
		'{3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0, 3'd0},
		'{3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0},
		'{3'd2, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0}
	};

endpackage

`default_nettype wire

@@ sv/fsel_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module fsel_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire fsel_pkg::div_req_t       in_req,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [fsel_pkg::QUO_W-1:0]    out_quo
);
	import fsel_pkg::*;

	logic [QUO_W:0]   en;
	logic [QUO_W-1:0] vld_q;
	logic [NUM_W-1:0] rem_q  [QUO_W-1];
	logic [DEN_W-1:0] den_q  [QUO_W-1];
	logic [QUO_W-1:0] quo_q  [QUO_W];
	logic             zero_q [QUO_W];

	assign en[QUO_W] = out_ready;
	assign in_ready  = en[0];
	assign out_valid = vld_q[QUO_W-1];
	assign out_quo   = zero_q[QUO_W-1] ? '0 : quo_q[QUO_W-1];

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		logic [NUM_W-1:0] rem_in;
		logic [DEN_W-1:0] den_in;
		logic [QUO_W-1:0] quo_in;
		logic             zero_in;
		logic             vld_in;
		logic [NUM_W:0]   dsh;
		logic             ge;

		assign en[i] = ~vld_q[i] | en[i+1];

		if (i == 0) begin : g_first
			assign rem_in  = in_req.num;
			assign den_in  = in_req.den;
			assign quo_in  = '0;
			assign zero_in = (in_req.den == '0);
			assign vld_in  = in_valid;
		end else begin : g_rest
			assign rem_in  = rem_q[i-1];
			assign den_in  = den_q[i-1];
			assign quo_in  = quo_q[i-1];
			assign zero_in = zero_q[i-1];
			assign vld_in  = vld_q[i-1];
		end

		assign dsh    = (NUM_W+1)'(den_in) << (QUO_W - 1 - i);
		assign ge     = ((NUM_W+1)'(rem_in) >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (en[i]) begin
				vld_q[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				quo_q[i]  <= {quo_in[QUO_W-2:0], ge};
				zero_q[i] <= zero_in;
			end
		end

		if (i < QUO_W - 1) begin : g_carry
			logic [NUM_W-1:0] rem_nx;

			assign rem_nx = ge ? (rem_in - dsh[NUM_W-1:0]) : rem_in;

			always_ff @(posedge clk) begin
				if (en[i]) begin
					rem_q[i] <= rem_nx;
					den_q[i] <= den_in;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/fuzzy_speed_select.sv @@
// Fuzzy speed selector: clamp, scale, membership, 7x7 rules, weighted average.
// Throughput: one beat per cycle while the output is not stalled; 8 front stages feed a 15-stage divider.
// A stalled output fills the pipeline; empty stages still take new beats.
// Reset empties the pipeline and loads the seven default speed centers.
`default_nettype none

module fuzzy_speed_select (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [31:0]                 s_axis_tdata,  // deviation, deviation_rate
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [15:0]                      m_axis_tdata,  // speed_value, zero pad
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [fsel_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [fsel_pkg::CTR_W-1:0]  cfg_data
);
	import fsel_pkg::*;

	localparam int NF = 8;

	typedef struct packed {
		logic [SEG_W-1:0] seg;
		logic [SCL_W-1:0] m0;
	} memb_t;

	function automatic memb_t member(input logic [SCL_W-1:0] s);
		memb_t            r;
		logic [3:0]       t;
		logic [8:0]       m;
		t = 4'(5'd16 - {1'b0, s[3:0]});
		m = 9'(25 * t);
		if (s == '0) begin
			r.seg = SEG_W'(1);
			r.m0  = SCL_W'(SCL_MAX);
		end else if (s >= SCL_W'(SEG_NUM * SEG_STEP)) begin
			r.seg = SEG_W'(SEG_NUM);
			r.m0  = '0;
		end else begin
			r.seg = s[6:4] + SEG_W'(s[3:0] != 4'd0);
			r.m0  = m[8:2];
		end
		return r;
	endfunction

	center_t centers_q [NUM_CTR];

	logic [NF+1:1] en;
	logic [NF:1]   vld_q;

	logic [DEV_W-1:0] dev_in;
	logic [DEV_W-1:0] rate_in;

	logic [DCL_W-1:0] dc_s1;
	logic [RCL_W-1:0] rc_s1;
	logic [SPROD_W-1:0] dprod;
	logic [SPROD_W-1:0] rprod;
	logic [SCL_W-1:0] ps_s2;
	logic [SCL_W-1:0] ds_s2;
	memb_t            pm_s3;
	memb_t            dm_s3;
	logic [LVL_W-1:0] lvl_c  [4];
	logic [WGT_W-1:0] w_c    [4];
	logic [LVL_W-1:0] lvl_s4 [4];
	logic [WGT_W-1:0] w_s4   [4];
	logic [WGT_W-1:0] wl_c   [NUM_CTR];
	logic [DEN_W-1:0] den_c;
	logic [WGT_W-1:0] wl_s5  [NUM_CTR];
	logic [DEN_W-1:0] den_s5;
	logic [PROD_W-1:0] prod_s6 [NUM_CTR];
	logic [DEN_W-1:0] den_s6;
	logic [PROD_W:0]  psum_s7 [4];
	logic [DEN_W-1:0] den_s7;
	div_req_t         req_s8;

	logic             div_ready;
	logic [QUO_W-1:0] quo;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CTR; i++) begin
				centers_q[i] <= CENTER_RESET[i];
			end
		end else if (cfg_valid && cfg_ready && (cfg_index < IDX_W'(NUM_CTR))) begin
			centers_q[cfg_index] <= cfg_data;
		end
	end

	assign en[NF+1]      = div_ready;
	assign s_axis_tready = en[1];

	for (genvar k = 1; k <= NF; k++) begin : g_en
		logic vld_in;

		assign en[k] = ~vld_q[k] | en[k+1];

		if (k == 1) begin : g_first
			assign vld_in = s_axis_tvalid;
		end else begin : g_rest
			assign vld_in = vld_q[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en[k]) begin
				vld_q[k] <= vld_in;
			end
		end
	end

	assign dev_in  = s_axis_tdata[15:0];
	assign rate_in = s_axis_tdata[31:16];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			if (dev_in[DEV_W-1]) begin
				dc_s1 <= '0;
			end else if (dev_in > DEV_W'(DEV_MAX)) begin
				dc_s1 <= DCL_W'(DEV_MAX);
			end else begin
				dc_s1 <= dev_in[DCL_W-1:0];
			end
			if (rate_in[DEV_W-1]) begin
				rc_s1 <= '0;
			end else if (rate_in > DEV_W'(RATE_MAX)) begin
				rc_s1 <= RCL_W'(RATE_MAX);
			end else begin
				rc_s1 <= rate_in[RCL_W-1:0];
			end
		end
	end

	assign dprod = SPROD_W'(dc_s1) * SPROD_W'(DEV_MUL);
	assign rprod = SPROD_W'(rc_s1) * SPROD_W'(RATE_MUL);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ps_s2 <= dprod[RECIP_SH +: SCL_W];
			ds_s2 <= rprod[RECIP_SH +: SCL_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			pm_s3 <= member(ps_s2);
			dm_s3 <= member(ds_s2);
		end
	end

	always_comb begin
		logic [SEG_W-1:0] pa;
		logic [SEG_W-1:0] da;
		logic [SCL_W-1:0] p1;
		logic [SCL_W-1:0] d1;
		pa = pm_s3.seg - SEG_W'(1);
		da = dm_s3.seg - SEG_W'(1);
		p1 = SCL_W'(SCL_MAX) - pm_s3.m0;
		d1 = SCL_W'(SCL_MAX) - dm_s3.m0;
		lvl_c[0] = RULE_TBL[pa][da];
		lvl_c[1] = RULE_TBL[pm_s3.seg][da];
		lvl_c[2] = RULE_TBL[pa][dm_s3.seg];
		lvl_c[3] = RULE_TBL[pm_s3.seg][dm_s3.seg];
		w_c[0] = (pm_s3.m0 < dm_s3.m0) ? pm_s3.m0 : dm_s3.m0;
		w_c[1] = (p1 < dm_s3.m0) ? p1 : dm_s3.m0;
		w_c[2] = (pm_s3.m0 < d1) ? pm_s3.m0 : d1;
		w_c[3] = (p1 < d1) ? p1 : d1;
		for (int a = 0; a < 3; a++) begin
			for (int b = a + 1; b < 4; b++) begin
				if (lvl_c[a] == lvl_c[b]) begin
					if (w_c[a] > w_c[b]) begin
						w_c[b] = '0;
					end else begin
						w_c[a] = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			lvl_s4 <= lvl_c;
			w_s4   <= w_c;
		end
	end

	// After merging, each output level keeps at most one nonzero weight.
	always_comb begin
		den_c = '0;
		for (int l = 0; l < NUM_CTR; l++) begin
			wl_c[l] = '0;
			for (int k = 0; k < 4; k++) begin
				if (lvl_s4[k] == LVL_W'(l)) begin
					wl_c[l] = wl_c[l] | w_s4[k];
				end
			end
		end
		for (int k = 0; k < 4; k++) begin
			den_c = den_c + DEN_W'(w_s4[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			wl_s5  <= wl_c;
			den_s5 <= den_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int l = 0; l < NUM_CTR; l++) begin
				prod_s6[l] <= PROD_W'(wl_s5[l]) * PROD_W'(centers_q[l]);
			end
			den_s6 <= den_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			psum_s7[0] <= (PROD_W+1)'(prod_s6[0]) + (PROD_W+1)'(prod_s6[1]);
			psum_s7[1] <= (PROD_W+1)'(prod_s6[2]) + (PROD_W+1)'(prod_s6[3]);
			psum_s7[2] <= (PROD_W+1)'(prod_s6[4]) + (PROD_W+1)'(prod_s6[5]);
			psum_s7[3] <= (PROD_W+1)'(prod_s6[6]);
			den_s7     <= den_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			req_s8.num <= NUM_W'(psum_s7[0]) + NUM_W'(psum_s7[1])
			            + NUM_W'(psum_s7[2]) + NUM_W'(psum_s7[3]);
			req_s8.den <= den_s7;
		end
	end

	fsel_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_q[NF]),
		.in_ready  (div_ready),
		.in_req    (req_s8),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_quo   (quo)
	);

	assign m_axis_tdata = {1'b0, quo};

endmodule

`default_nettype wire
